FILE: design/stable_priority_queue_assert.svh
// Assertion macros used by the checker of the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/spq_pkg.sv
// Package with the codes, defaults and transfer types of the stable priority queue.
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF   = 64;
	localparam int PRIO_W_DEF  = 8;
	localparam int TAG_W       = 16;
	localparam int REQ_PRIO_W  = 8;

	// Operation codes.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SERVE  = 2'd1;
	localparam logic [1:0] ACT_IGNORE = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SERVED = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]            action;
		logic [TAG_W-1:0]      tag;
		logic [REQ_PRIO_W-1:0] priority_req;
	} spq_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [TAG_W-1:0] served_tag;
	} spq_out_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic insert;
		logic shift;
	} spq_cmd_t;

endpackage

`default_nettype wire

FILE: design/stable_priority_queue.sv
// Top level of the stable priority queue: controller and the chain of sorted cells.
`default_nettype none

// Bounded priority queue kept as a chain of DEPTH cells sorted by priority, with
// the earliest arrival first among equal priorities. An operation is transferred
// when start is high and busy is low; busy then stays high for one cycle, and the
// result is shown behind the pending and done registers, for one cycle, marked
// by done.
// No new operation is taken while one is pending: it is first registered, then
// every cell compares the new priority and moves an entry to or from its neighbor.
// The receiver must take each result in its done cycle. A serve on an empty queue
// answers empty, an insert into a full queue is refused and answers full, and an
// ignored or unused operation answers zero status.
module stable_priority_queue #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIO_W_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire spq_pkg::spq_in_t  op,
	output logic                   busy,
	output logic                   done,
	output spq_pkg::spq_out_t      result
);

	spq_pkg::spq_cmd_t                cmd;
	logic [spq_pkg::TAG_W-1:0]        new_tag;
	logic [PRIORITY_WIDTH-1:0]        new_prio;
	logic [DEPTH-1:0]                 valid;
	logic [DEPTH-1:0]                 lower;
	logic [spq_pkg::TAG_W-1:0]        cell_tag  [DEPTH];
	logic [PRIORITY_WIDTH-1:0]        cell_prio [DEPTH];

	spq_ctrl #(
		.DEPTH          (DEPTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op),
		.head_tag (cell_tag[0]),
		.busy     (busy),
		.cmd      (cmd),
		.new_tag  (new_tag),
		.new_prio (new_prio),
		.valid    (valid),
		.done     (done),
		.result   (result)
	);

	// The chain; the head has no left neighbor and the tail refills from itself.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      left_lower;
		logic [spq_pkg::TAG_W-1:0] left_tag;
		logic [PRIORITY_WIDTH-1:0] left_prio;
		logic [spq_pkg::TAG_W-1:0] right_tag;
		logic [PRIORITY_WIDTH-1:0] right_prio;

		if (i == 0) begin : g_head
			assign left_lower = 1'b0;
			assign left_tag   = new_tag;
			assign left_prio  = new_prio;
		end else begin : g_mid
			assign left_lower = lower[i-1];
			assign left_tag   = cell_tag[i-1];
			assign left_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_tag  = cell_tag[i];
			assign right_prio = cell_prio[i];
		end else begin : g_body
			assign right_tag  = cell_tag[i+1];
			assign right_prio = cell_prio[i+1];
		end

		spq_cell #(
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (valid[i]),
			.new_tag    (new_tag),
			.new_prio   (new_prio),
			.left_lower (left_lower),
			.left_tag   (left_tag),
			.left_prio  (left_prio),
			.right_tag  (right_tag),
			.right_prio (right_prio),
			.tag_q      (cell_tag[i]),
			.prio_q     (cell_prio[i]),
			.lower      (lower[i])
		);
	end

endmodule

`default_nettype wire

FILE: design/spq_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none

module spq_cell #(
	parameter int PRIORITY_WIDTH = spq_pkg::PRIO_W_DEF
) (
	input  wire logic                      clk,
	input  wire spq_pkg::spq_cmd_t         cmd,
	input  wire logic                      valid,
	input  wire logic [spq_pkg::TAG_W-1:0] new_tag,
	input  wire logic [PRIORITY_WIDTH-1:0] new_prio,
	input  wire logic                      left_lower,
	input  wire logic [spq_pkg::TAG_W-1:0] left_tag,
	input  wire logic [PRIORITY_WIDTH-1:0] left_prio,
	input  wire logic [spq_pkg::TAG_W-1:0] right_tag,
	input  wire logic [PRIORITY_WIDTH-1:0] right_prio,
	output logic [spq_pkg::TAG_W-1:0]      tag_q,
	output logic [PRIORITY_WIDTH-1:0]      prio_q,
	output logic                           lower
);

	// An empty cell or a strictly lower priority yields to the new entry; equal
	// priorities stay ahead, which keeps arrival order among ties.
	assign lower = !valid || (prio_q < new_prio);

	// Shift toward the head on a serve; on an insert the first yielding cell takes
	// the new entry and every yielding cell behind it takes its left neighbor.
	always_ff @(posedge clk) begin
		priority if (cmd.shift) begin
			tag_q  <= right_tag;
			prio_q <= right_prio;
		end else if (cmd.insert && lower && !left_lower) begin
			tag_q  <= new_tag;
			prio_q <= new_prio;
		end else if (cmd.insert && lower && left_lower) begin
			tag_q  <= left_tag;
			prio_q <= left_prio;
		end
	end

endmodule

`default_nettype wire

FILE: design/spq_ctrl.sv
// Controller of the stable priority queue: command register, fill count and result.
`default_nettype none

module spq_ctrl #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIO_W_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire spq_pkg::spq_in_t          op,
	input  wire logic [spq_pkg::TAG_W-1:0] head_tag,
	output logic                           busy,
	output spq_pkg::spq_cmd_t              cmd,
	output logic [spq_pkg::TAG_W-1:0]      new_tag,
	output logic [PRIORITY_WIDTH-1:0]      new_prio,
	output logic [DEPTH-1:0]               valid,
	output logic                           done,
	output spq_pkg::spq_out_t              result
);

	localparam int CW = $clog2(DEPTH + 1);

	logic             pend_s1;
	logic [1:0]       act_s1;
	logic [CW-1:0]    count_q;
	logic             done_q;
	spq_pkg::spq_out_t result_q;
	logic [31:0]      req_prio_ext;
	logic             full;
	logic             empty;
	logic             accept;

	assign accept       = start && !busy;
	assign busy         = pend_s1;
	assign full         = (count_q == CW'(DEPTH));
	assign empty        = (count_q == '0);
	assign req_prio_ext = 32'(op.priority_req);

	// Command to the chain for the registered operation.
	assign cmd.insert = pend_s1 && (act_s1 == spq_pkg::ACT_INSERT) && !full;
	assign cmd.shift  = pend_s1 && (act_s1 == spq_pkg::ACT_SERVE) && !empty;

	// A cell holds an entry when its position lies below the fill count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_valid
		assign valid[i] = (CW'(i) < count_q);
	end

	// Operation register, payload only.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= op.action;
			new_tag  <= op.tag;
			new_prio <= req_prio_ext[PRIORITY_WIDTH-1:0];
		end
	end

	// Control state: pending flag, fill count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			pend_s1 <= accept;
			done_q  <= pend_s1;
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.shift) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Result of the operation, taken from the head cell on a serve.
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			unique case (act_s1)
				spq_pkg::ACT_INSERT: begin
					result_q.status     <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
					result_q.served_tag <= '0;
				end
				spq_pkg::ACT_SERVE: begin
					if (empty) begin
						result_q.status     <= spq_pkg::ST_EMPTY;
						result_q.served_tag <= '0;
					end else begin
						result_q.status     <= spq_pkg::ST_SERVED;
						result_q.served_tag <= head_tag;
					end
				end
				default: begin
					result_q.status     <= spq_pkg::ST_OK;
					result_q.served_tag <= '0;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: design/spq_check.sv
// Port checker of the stable priority queue and its bind to the top level.
`default_nettype none

`include "stable_priority_queue_assert.svh"

module spq_check (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire spq_pkg::spq_out_t result
);

	// A transfer makes the block busy in the next cycle.
	`SPQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after transfer")

	// Every transfer is answered by done behind the pending and done registers.
	`SPQ_ASSERT_IMPL(a_done_latency, start && !busy, ##2 done, "result not delivered on time")

	// The result strobe lasts one cycle.
	`SPQ_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

	// A new operation is taken in the cycle its predecessor answers.
	`SPQ_ASSERT_IMPL(a_ready_at_done, done, !busy, "busy while result is shown")

	// Only a served result carries a tag.
	`SPQ_ASSERT_IMPL(a_tag_zero, done && (result.status != spq_pkg::ST_SERVED), result.served_tag == '0, "tag on a result that is not served")

endmodule

bind stable_priority_queue spq_check u_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
